/* hw/rtl/pwt_pkg.sv */
// Shared types and constants for the Prewitt edge threshold block.
// Used by pwt_grad, pwt_fifo and prewitt_edge_threshold; depends on nothing.
`default_nettype none

package pwt_pkg;

  localparam int PIX_W      = 8;
  localparam int THR_W      = 11;
  localparam int WID_W      = 11;
  localparam int HEI_W      = 13;
  localparam int OUT_X_W    = 10;
  localparam int OUT_Y_W    = 12;
  localparam int GRAD_W     = 11;
  localparam int SUM_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd128;
  localparam logic [WID_W-1:0] WIDTH_RESET     = 11'd1024;
  localparam logic [HEI_W-1:0] HEIGHT_RESET    = 13'd768;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic               emit;
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    logic               last;
  } pwt_tag_t;

  typedef struct packed {
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    logic [PIX_W-1:0]   edge_value;
    logic               last;
  } pwt_result_t;

endpackage

`default_nettype wire

/* hw/rtl/pwt_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pwt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/pwt_grad.sv */
// 3x3 window registers, Prewitt gradients and threshold compare.
// Two stages: gradients, then magnitude and compare. Depends on pwt_pkg.
`default_nettype none

module pwt_grad (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire pwt_pkg::pwt_tag_t           in_tag,
  input  wire logic [pwt_pkg::PIX_W-1:0]   top,
  input  wire logic [pwt_pkg::PIX_W-1:0]   mid,
  input  wire logic [pwt_pkg::PIX_W-1:0]   bot,
  input  wire logic [pwt_pkg::THR_W-1:0]   threshold,
  output logic                             busy,
  output logic                             push,
  output pwt_pkg::pwt_result_t             push_data
);

  import pwt_pkg::*;

  logic [PIX_W-1:0] win [6];

  logic [SUM_W-1:0] left_sum, right_sum, upper_sum, lower_sum;
  logic signed [GRAD_W-1:0] gx_next, gy_next;

  logic                     s2_valid;
  pwt_tag_t                 s2_tag;
  logic signed [GRAD_W-1:0] gx, gy;

  logic [GRAD_W-1:0] abs_gx, abs_gy, mag;

  always_comb begin
    left_sum  = SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]);
    right_sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(bot);
    upper_sum = SUM_W'(win[0]) + SUM_W'(win[3]) + SUM_W'(top);
    lower_sum = SUM_W'(win[2]) + SUM_W'(win[5]) + SUM_W'(bot);
    gx_next   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    gy_next   = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      if (in_valid) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= top;
        win[4] <= mid;
        win[5] <= bot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      s2_tag <= in_tag;
      gx     <= gx_next;
      gy     <= gy_next;
    end
  end

  always_comb begin
    abs_gx = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
    abs_gy = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
    mag    = abs_gx + abs_gy;
    push   = s2_valid && s2_tag.emit;
    push_data.x          = s2_tag.x;
    push_data.y          = s2_tag.y;
    push_data.edge_value = (mag >= threshold) ? EDGE_ON : EDGE_OFF;
    push_data.last       = s2_tag.last;
  end

  assign busy = s2_valid;

endmodule

`default_nettype wire

/* hw/rtl/pwt_fifo.sv */
// Result queue between the gradient pipeline and the output channel.
// Four entries, head read combinationally. Depends on pwt_pkg.
`default_nettype none

module pwt_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire pwt_pkg::pwt_result_t          push_data,
  input  wire logic                          pop,
  output pwt_pkg::pwt_result_t               head,
  output logic [pwt_pkg::FIFO_CW-1:0]        count
);

  import pwt_pkg::*;

  pwt_result_t        entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head = entries[rd_ptr];

endmodule

`default_nettype wire

/* hw/rtl/prewitt_edge_threshold.sv */
// Top level of the Prewitt edge threshold block: registers, position counters,
// line store RAM with read-modify-write, gradient pipeline and result queue.
// Depends on pwt_pkg, pwt_ram, pwt_grad, pwt_fifo.
//
//  channel  | handshake                  | beat contents
//  ---------+----------------------------+------------------------------------
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  pixel in | pixel_valid / pixel_ready  | pixel
//  result   | result_valid / result_ready| out_x, out_y, edge_value,
//           |                            |   last_of_frame
//
// One pixel per cycle sustained while result_ready stays high. A result passes
// the s1 and s2 registers into the four-entry queue and can leave on the next cycle.
// After reset the line store is cleared one entry a cycle, all MAX_WIDTH
// entries, with pixel_ready low; config writes are taken throughout.
// pixel_ready drops when queued results plus pixels in flight reach four.
`default_nettype none

module prewitt_edge_threshold #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pwt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pwt_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             pixel_valid,
  output logic                                  pixel_ready,
  input  wire logic [pwt_pkg::PIX_W-1:0]        pixel,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [pwt_pkg::OUT_X_W-1:0]           out_x,
  output logic [pwt_pkg::OUT_Y_W-1:0]           out_y,
  output logic [pwt_pkg::PIX_W-1:0]             edge_value,
  output logic                                  last_of_frame
);

  import pwt_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LW = 2 * PIX_W;

  logic [THR_W-1:0] threshold;
  logic [WID_W-1:0] image_width;
  logic [HEI_W-1:0] image_height;

  logic [31:0]   w_full, h_full;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;

  logic          clearing;
  logic [CW-1:0] clr_addr;

  logic          accept;
  pwt_tag_t      tag_next;
  logic [31:0]   x_full, y_full;

  logic             s1_valid;
  pwt_tag_t         s1_tag;
  logic [PIX_W-1:0] s1_bot;
  logic [CW-1:0]    s1_addr;

  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;

  logic          grad_busy;
  logic          push;
  pwt_result_t   push_data;
  pwt_result_t   head;
  logic [FIFO_CW-1:0] q_count;
  logic [FIFO_CW-1:0] inflight;
  logic          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold    <= cfg_data[THR_W-1:0];
        REG_WIDTH:     image_width  <= cfg_data[WID_W-1:0];
        REG_HEIGHT:    image_height <= cfg_data[HEI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) < 32'd3) begin
      w_full = 32'd3;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = 32'(image_width);
    end
    if (32'(image_height) < 32'd3) begin
      h_full = 32'd3;
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = 32'(image_height);
    end
    w_eff = w_full[WW-1:0];
    h_eff = h_full[HW-1:0];
  end

  assign inflight    = q_count + FIFO_CW'(s1_valid) + FIFO_CW'(grad_busy);
  assign pixel_ready = !clearing && (inflight < FIFO_CW'(FIFO_DEPTH));
  assign accept      = pixel_valid && pixel_ready;

  always_comb begin
    x_full        = 32'(col) - 32'd1;
    y_full        = 32'(row) - 32'd1;
    tag_next.emit = (32'(col) >= 32'd2) && (32'(row) >= 32'd2) &&
                    (32'(col) < 32'(w_eff)) && (32'(row) < 32'(h_eff));
    tag_next.x    = x_full[OUT_X_W-1:0];
    tag_next.y    = y_full[OUT_Y_W-1:0];
    tag_next.last = (32'(col) == 32'(w_eff) - 32'd1) &&
                    (32'(row) == 32'(h_eff) - 32'd1);
    col_next = col;
    row_next = row;
    if (32'(col) + 32'd1 >= 32'(w_eff)) begin
      col_next = '0;
      row_next = (32'(row) + 32'd1 >= 32'(h_eff)) ? '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (32'(clr_addr) == 32'(MAX_WIDTH) - 32'd1) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tag  <= tag_next;
      s1_bot  <= pixel;
      s1_addr <= col;
    end
  end

  // write back {mid, bot} to the entry read last cycle, or zeros while clearing; shift rows up
  always_comb begin
    ram_we    = clearing || s1_valid;
    ram_waddr = clearing ? clr_addr : s1_addr;
    ram_wdata = clearing ? '0 : {ram_rdata[PIX_W-1:0], s1_bot};
  end

  pwt_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col),
    .rdata (ram_rdata)
  );

  pwt_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_tag    (s1_tag),
    .top       (ram_rdata[LW-1:PIX_W]),
    .mid       (ram_rdata[PIX_W-1:0]),
    .bot       (s1_bot),
    .threshold (threshold),
    .busy      (grad_busy),
    .push      (push),
    .push_data (push_data)
  );

  assign result_valid = (q_count != '0);
  assign pop          = result_valid && result_ready;

  pwt_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  assign out_x         = head.x;
  assign out_y         = head.y;
  assign edge_value    = head.edge_value;
  assign last_of_frame = head.last;

endmodule

`default_nettype wire

/* tb/sv/prewitt_edge_threshold_tb.sv */
// Self-checking testbench for prewitt_edge_threshold: drives pixel and register beats,
// predicts each thresholded Prewitt result in a scoreboard class and checks every result beat.
// Depends on pwt_pkg and the prewitt_edge_threshold RTL.
module prewitt_edge_threshold_tb;
  import pwt_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int RANDOM_ITEMS  = 160;
  localparam int CALM_ITEMS    = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [PIX_W-1:0] RAMP_PATCH [9] = '{
    8'd0, 8'd0,   8'd0,
    8'd0, 8'd128, 8'd255,
    8'd0, 8'd255, 8'd255
  };

  typedef enum int {PAT_UNIFORM, PAT_EXTREME, PAT_SMOOTH} pattern_t;

  class edge_predictor;
    int unsigned errors;
    logic [THR_W-1:0] threshold;
    logic [WID_W-1:0] width_reg;
    logic [HEI_W-1:0] height_reg;
    logic [PIX_W-1:0] row_above2 [MAX_W];
    logic [PIX_W-1:0] row_above1 [MAX_W];
    logic [PIX_W-1:0] window [6];
    int unsigned col;
    int unsigned row;
    pwt_result_t pending_edges [$];

    function new();
      threshold  = THRESHOLD_RESET;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (row_above2[i]) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold  = data[THR_W-1:0];
        REG_WIDTH:     width_reg  = data[WID_W-1:0];
        REG_HEIGHT:    height_reg = data[HEI_W-1:0];
        default: ;
      endcase
    endfunction

    function bit frame_start();
      return col == 0 && row == 0;
    endfunction

    function int pending();
      return pending_edges.size();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned w, h, c, r;
      logic [PIX_W-1:0] top, mid;
      int gx, gy, g;
      pwt_result_t res;
      w   = clamp_dim(width_reg, MAX_W);
      h   = clamp_dim(height_reg, MAX_H);
      c   = col;
      r   = row;
      top = row_above2[c];
      mid = row_above1[c];
      row_above2[c] = mid;
      row_above1[c] = p;
      if (c >= 2 && r >= 2 && c < w && r < h) begin
        gx = (int'(top) + int'(mid) + int'(p))
           - (int'(window[0]) + int'(window[1]) + int'(window[2]));
        gy = (int'(window[2]) + int'(window[5]) + int'(p))
           - (int'(window[0]) + int'(window[3]) + int'(top));
        g = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        res.x          = OUT_X_W'(c - 1);
        res.y          = OUT_Y_W'(r - 1);
        res.edge_value = (g >= int'(threshold)) ? EDGE_ON : EDGE_OFF;
        res.last       = (c == w - 1 && r == h - 1);
        pending_edges.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top;
      window[4] = mid;
      window[5] = p;
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_result(logic [OUT_X_W-1:0] x, logic [OUT_Y_W-1:0] y,
                               logic [PIX_W-1:0] ev, logic last);
      pwt_result_t want;
      if (pending_edges.size() == 0) begin
        report($sformatf("result x=%0d y=%0d with nothing expected", x, y));
      end else begin
        want = pending_edges.pop_front();
        if (x !== want.x)
          report($sformatf("out_x %0d, expected %0d", x, want.x));
        if (y !== want.y)
          report($sformatf("out_y %0d, expected %0d", y, want.y));
        if (ev !== want.edge_value)
          report($sformatf("edge_value %0d at (%0d,%0d), expected %0d",
                           ev, want.x, want.y, want.edge_value));
        if (last !== want.last)
          report($sformatf("last_of_frame %0b at (%0d,%0d), expected %0b",
                           last, want.x, want.y, want.last));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  pixel_valid;
  logic                  pixel_ready;
  logic [PIX_W-1:0]      pixel;
  logic                  result_valid;
  logic                  result_ready;
  logic [OUT_X_W-1:0]    out_x;
  logic [OUT_Y_W-1:0]    out_y;
  logic [PIX_W-1:0]      edge_value;
  logic                  last_of_frame;

  edge_predictor edges;
  int gap_pct;
  int stall_pct;
  int cycles = 0;
  logic [PIX_W-1:0] last_px = '0;

  prewitt_edge_threshold #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_x        (out_x),
    .out_y        (out_y),
    .edge_value   (edge_value),
    .last_of_frame(last_of_frame)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("prewitt_edge_threshold_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      edges.check_result(out_x, out_y, edge_value, last_of_frame);
  end

  initial begin
    result_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel(pattern_t pat);
    int v;
    case (pat)
      PAT_UNIFORM: v = $urandom_range(0, 255);
      PAT_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
      default: begin
        v = int'(last_px) + int'($urandom_range(0, 24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    last_px = PIX_W'(v);
    return last_px;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    edges.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if ($urandom_range(0, 99) < gap_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    edges.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic end_phase();
    pixel_valid <= 1'b0;
    while (edges.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic pick_config();
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_THRESHOLD, '0);
        1: write_reg(REG_THRESHOLD, CFG_DATA_W'(1530));
        2: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 8191)));
        3: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 80)));
        default: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 1100)));
      endcase
    end
    if ($urandom_range(0, 9) < 4)
      write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(0, 7) == 0 ?
                                        $urandom_range(0, 2) : $urandom_range(3, 12)));
    if ($urandom_range(0, 9) < 4)
      write_reg(REG_HEIGHT, CFG_DATA_W'($urandom_range(0, 7) == 0 ?
                                         $urandom_range(0, 2) : $urandom_range(3, 8)));
    if ($urandom_range(0, 15) == 0)
      write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
  endtask

  task automatic random_phase(input bit quiet, inout int total);
    int n;
    pattern_t pat;
    pick_config();
    if (quiet) begin
      gap_pct   = 0;
      stall_pct = 0;
    end else begin
      gap_pct   = 20 * $urandom_range(0, 2);
      stall_pct = 20 * $urandom_range(0, 2);
    end
    n   = $urandom_range(8, 90);
    pat = pattern_t'($urandom_range(0, 2));
    repeat (n) begin
      send_pixel(next_pixel(pat));
      total++;
    end
    end_phase();
  endtask

  initial begin
    int sent;
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pixel_valid = 1'b0;
    pixel       = '0;
    gap_pct     = 0;
    stall_pct   = 0;
    sent        = 0;
    edges       = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_HEIGHT, CFG_DATA_W'(3));
    repeat (9) send_pixel('0);
    end_phase();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(1020));
    foreach (RAMP_PATCH[i]) send_pixel(RAMP_PATCH[i]);
    end_phase();
    write_reg(REG_THRESHOLD, '1);
    foreach (RAMP_PATCH[i]) send_pixel(RAMP_PATCH[i]);
    end_phase();

    while (sent < RANDOM_ITEMS) random_phase(1'b0, sent);

    gap_pct   = 20;
    stall_pct = 20;
    write_reg(REG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_HEIGHT, CFG_DATA_W'(3));
    while (!edges.frame_start()) send_pixel(next_pixel(PAT_UNIFORM));
    end_phase();
    write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(100, 700)));
    repeat (6) send_pixel(next_pixel(PAT_SMOOTH));
    end_phase();
    write_reg(REG_WIDTH, '1);
    repeat (MAX_W) send_pixel(next_pixel(pattern_t'($urandom_range(0, 2))));
    end_phase();
    write_reg(REG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_HEIGHT, '1);
    repeat (90) send_pixel(next_pixel(PAT_UNIFORM));
    end_phase();

    sent = 0;
    while (sent < CALM_ITEMS) random_phase(1'b1, sent);

    if (edges.errors == 0 && edges.pending() == 0)
      $display("prewitt_edge_threshold_tb passed");
    else
      $display("prewitt_edge_threshold_tb failed");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/pwt_pkg.sv
hw/rtl/pwt_ram.sv
hw/rtl/pwt_grad.sv
hw/rtl/pwt_fifo.sv
hw/rtl/prewitt_edge_threshold.sv
tb/sv/prewitt_edge_threshold_tb.sv
